### design/dtfp_pkg.sv
package dtfp_pkg;

  // defaults for the top level parameters
  localparam int VALUE_WIDTH_DEF         = 48;
  localparam int MAX_FRACTION_DIGITS_DEF = 9;

  // fixed field widths
  localparam int CHAR_W  = 8;
  localparam int CFG_W   = 4;
  localparam int CNT_W   = 4;
  localparam int DIGIT_W = 4;

  localparam logic [CFG_W-1:0] FRACTION_DIGITS_RESET = 4'd4;

  // ascii codes the parser recognizes
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;

  // side information that travels with a magnitude through the scaling chain
  typedef struct packed {
    logic             neg;
    logic             err;
    logic             ovf;
    logic [CNT_W-1:0] rem;
  } stage_flags_t;

endpackage

### design/dtfp_if.sv
interface dtfp_char_if;
  import dtfp_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface dtfp_result_if #(
  parameter int VALUE_WIDTH = dtfp_pkg::VALUE_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] scaled_value;
  logic                          bad_character;
  logic                          overflowed;

  modport source (output valid, output scaled_value, output bad_character,
                  output overflowed, input ready);
  modport sink   (input valid, input scaled_value, input bad_character,
                  input overflowed, output ready);
endinterface

### design/dtfp_mul10_sat.sv
module dtfp_mul10_sat #(
  parameter int VALUE_WIDTH = dtfp_pkg::VALUE_WIDTH_DEF
) (
  input  logic [VALUE_WIDTH-1:0]      mag,
  input  logic [dtfp_pkg::DIGIT_W-1:0] digit,
  input  logic                        neg,
  output logic [VALUE_WIDTH-1:0]      result,
  output logic                        sat
);
  import dtfp_pkg::*;

  localparam int EW = VALUE_WIDTH + 4;

  logic [EW-1:0] mag_ext;
  logic [EW-1:0] prod;
  logic [EW-1:0] half;
  logic [EW-1:0] lim;

  // mag * 10 + digit as two shifts and adds
  assign mag_ext = EW'(mag);
  assign prod    = (mag_ext << 3) + (mag_ext << 1) + EW'(digit);

  // magnitude limit: one more for negative numbers
  assign half = EW'(1) << (VALUE_WIDTH - 1);
  assign lim  = neg ? half : half - EW'(1);

  assign sat    = prod > lim;
  assign result = sat ? lim[VALUE_WIDTH-1:0] : prod[VALUE_WIDTH-1:0];

endmodule

### design/dtfp_parser.sv
module dtfp_parser #(
  parameter int VALUE_WIDTH = dtfp_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dtfp_pkg::CHAR_W-1:0]   char_code,
  input  logic                          last_char,
  input  logic [dtfp_pkg::CNT_W-1:0]    fd_active,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [VALUE_WIDTH-1:0]        out_mag,
  output dtfp_pkg::stage_flags_t        out_flags
);
  import dtfp_pkg::*;

  // parser state
  logic [VALUE_WIDTH-1:0] acc;
  logic [CNT_W-1:0]       frac_cnt;
  logic                   dot_seen;
  logic                   is_negative;
  logic                   at_first;
  logic                   err_seen;
  logic                   ovf_seen;

  // updated state for the current character
  logic [VALUE_WIDTH-1:0] acc_next;
  logic [CNT_W-1:0]       frac_cnt_next;
  logic                   dot_seen_next;
  logic                   is_negative_next;
  logic                   err_seen_next;
  logic                   ovf_seen_next;
  logic [CNT_W-1:0]       rem_next;

  logic                   is_digit;
  logic                   is_dot;
  logic                   is_sign;
  logic                   frac_room;
  logic                   take_digit;
  logic [DIGIT_W-1:0]     digit;
  logic [VALUE_WIDTH-1:0] acc_step;
  logic                   step_sat;
  logic                   accept;

  assign accept   = in_valid && in_ready;
  assign in_ready = !out_valid || out_ready;
  assign digit    = DIGIT_W'(char_code - CHAR_ZERO);

  dtfp_mul10_sat #(.VALUE_WIDTH(VALUE_WIDTH)) u_mul10 (
    .mag    (acc),
    .digit  (digit),
    .neg    (is_negative),
    .result (acc_step),
    .sat    (step_sat)
  );

  always_comb begin
    is_digit   = char_code inside {[CHAR_ZERO:CHAR_NINE]};
    is_dot     = char_code == CHAR_DOT;
    is_sign    = char_code inside {CHAR_PLUS, CHAR_MINUS};
    frac_room  = frac_cnt < fd_active;
    take_digit = is_digit && (!dot_seen || frac_room);

    acc_next         = take_digit ? acc_step : acc;
    ovf_seen_next    = ovf_seen || (take_digit && step_sat);
    frac_cnt_next    = (is_digit && dot_seen && frac_room) ? frac_cnt + CNT_W'(1) : frac_cnt;
    dot_seen_next    = dot_seen || is_dot;
    is_negative_next = (at_first && is_sign) ? (char_code == CHAR_MINUS) : is_negative;
    err_seen_next    = err_seen || (is_dot && dot_seen) ||
                       (!is_digit && !is_dot && !(is_sign && at_first));
    // missing fraction digits, none if more were taken than now asked for
    rem_next         = (fd_active > frac_cnt_next) ? fd_active - frac_cnt_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc         <= '0;
      frac_cnt    <= '0;
      dot_seen    <= 1'b0;
      is_negative <= 1'b0;
      at_first    <= 1'b1;
      err_seen    <= 1'b0;
      ovf_seen    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        if (last_char) begin
          // hand the number on and start over
          acc         <= '0;
          frac_cnt    <= '0;
          dot_seen    <= 1'b0;
          is_negative <= 1'b0;
          at_first    <= 1'b1;
          err_seen    <= 1'b0;
          ovf_seen    <= 1'b0;
          out_valid   <= 1'b1;
        end else begin
          acc         <= acc_next;
          frac_cnt    <= frac_cnt_next;
          dot_seen    <= dot_seen_next;
          is_negative <= is_negative_next;
          at_first    <= 1'b0;
          err_seen    <= err_seen_next;
          ovf_seen    <= ovf_seen_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_char) begin
      out_mag       <= acc_next;
      out_flags.neg <= is_negative_next;
      out_flags.err <= err_seen_next;
      out_flags.ovf <= ovf_seen_next;
      out_flags.rem <= rem_next;
    end
  end

endmodule

### design/dtfp_scale_stage.sv
module dtfp_scale_stage #(
  parameter int VALUE_WIDTH = dtfp_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [VALUE_WIDTH-1:0] in_mag,
  input  dtfp_pkg::stage_flags_t in_flags,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [VALUE_WIDTH-1:0] out_mag,
  output dtfp_pkg::stage_flags_t out_flags
);
  import dtfp_pkg::*;

  logic [VALUE_WIDTH-1:0] step_mag;
  logic                   step_sat;
  logic                   do_step;

  assign in_ready = !out_valid || out_ready;
  assign do_step  = in_flags.rem != '0;

  dtfp_mul10_sat #(.VALUE_WIDTH(VALUE_WIDTH)) u_mul10 (
    .mag    (in_mag),
    .digit  ('0),
    .neg    (in_flags.neg),
    .result (step_mag),
    .sat    (step_sat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // one conditional times ten per stage
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_mag       <= do_step ? step_mag : in_mag;
      out_flags.neg <= in_flags.neg;
      out_flags.err <= in_flags.err;
      out_flags.ovf <= in_flags.ovf || (do_step && step_sat);
      out_flags.rem <= do_step ? in_flags.rem - CNT_W'(1) : in_flags.rem;
    end
  end

endmodule

### design/decimal_text_to_fixed_point_unit.sv
// a request with last_char set is registered in the parser output register, then in each scaling stage
// throughput: one character request per cycle while the chain does not stall, set by the
//   accumulator update, which is combinational; the scaling chain has one register per possible missing digit
// results can wait at the output while further characters are taken
// reset (rst, synchronous, active high): parser cleared, chain empty, fraction_digits = 4
module decimal_text_to_fixed_point_unit #(
  parameter int VALUE_WIDTH         = dtfp_pkg::VALUE_WIDTH_DEF,
  parameter int MAX_FRACTION_DIGITS = dtfp_pkg::MAX_FRACTION_DIGITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [dtfp_pkg::CFG_W-1:0] cfg_wr_data,
  dtfp_char_if.sink                  chars,
  dtfp_result_if.source              results
);
  import dtfp_pkg::*;

  localparam int NST = MAX_FRACTION_DIGITS + 1;

  // fraction_digits register and its clamp to the supported maximum
  logic [CFG_W-1:0] frac_digits;
  logic [CNT_W-1:0] fd_active;

  always_ff @(posedge clk) begin
    if (rst) begin
      frac_digits <= FRACTION_DIGITS_RESET;
    end else if (cfg_wr_en) begin
      frac_digits <= cfg_wr_data;
    end
  end

  assign fd_active = (frac_digits > CFG_W'(MAX_FRACTION_DIGITS)) ?
                     CNT_W'(MAX_FRACTION_DIGITS) : CNT_W'(frac_digits);

  // chain links: link 0 is the parser output register, the last link feeds the port
  logic                   valid_c [NST];
  logic                   ready_c [NST];
  logic [VALUE_WIDTH-1:0] mag_c   [NST];
  stage_flags_t           flags_c [NST];

  // character parser, accumulates digits and emits the raw magnitude on the last character
  dtfp_parser #(.VALUE_WIDTH(VALUE_WIDTH)) u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (chars.valid),
    .in_ready  (chars.ready),
    .char_code (chars.char_code),
    .last_char (chars.last_char),
    .fd_active (fd_active),
    .out_valid (valid_c[0]),
    .out_ready (ready_c[0]),
    .out_mag   (mag_c[0]),
    .out_flags (flags_c[0])
  );

  // scaling chain: each stage multiplies by ten while fraction digits are still missing,
  // saturating at the signed limit; empty stages let a request move up
  for (genvar g = 1; g < NST; g++) begin : g_stage
    dtfp_scale_stage #(.VALUE_WIDTH(VALUE_WIDTH)) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid_c[g-1]),
      .in_ready  (ready_c[g-1]),
      .in_mag    (mag_c[g-1]),
      .in_flags  (flags_c[g-1]),
      .out_valid (valid_c[g]),
      .out_ready (ready_c[g]),
      .out_mag   (mag_c[g]),
      .out_flags (flags_c[g])
    );
  end

  // result port, sign applied on the way out; negative zero comes out as zero
  assign ready_c[NST-1]        = results.ready;
  assign results.valid         = valid_c[NST-1];
  assign results.scaled_value  = flags_c[NST-1].neg ? VALUE_WIDTH'(0) - mag_c[NST-1]
                                                    : mag_c[NST-1];
  assign results.bad_character = flags_c[NST-1].err;
  assign results.overflowed    = flags_c[NST-1].ovf;

endmodule

### design/dtfp_checker.sv
module dtfp_checker #(
  parameter int VALUE_WIDTH         = dtfp_pkg::VALUE_WIDTH_DEF,
  parameter int MAX_FRACTION_DIGITS = dtfp_pkg::MAX_FRACTION_DIGITS_DEF
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   in_last,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [VALUE_WIDTH-1:0] out_value,
  input logic                   out_bad,
  input logic                   out_ovf
);
  localparam int DEPTH = MAX_FRACTION_DIGITS + 1;
  localparam int PW    = $clog2(DEPTH + 2);

  // numbers taken in but not yet delivered
  logic [PW-1:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + PW'(in_valid && in_ready && in_last)
                         - PW'(out_valid && out_ready);
    end
  end

  // no result without a finished number
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != '0)
    else $error("result without a pending number");

  // chain holds at most one number per stage
  a_depth: assert property (@(posedge clk) disable iff (rst)
    pending <= PW'(DEPTH))
    else $error("more numbers in flight than stages");

  // an empty chain always takes characters
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    pending == '0 |-> in_ready)
    else $error("not ready while empty");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value) &&
                                $stable(out_bad) && $stable(out_ovf))
    else $error("stalled result changed");

endmodule

bind decimal_text_to_fixed_point_unit dtfp_checker #(
  .VALUE_WIDTH         (VALUE_WIDTH),
  .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS)
) u_dtfp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (chars.valid),
  .in_ready  (chars.ready),
  .in_last   (chars.last_char),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_value (results.scaled_value),
  .out_bad   (results.bad_character),
  .out_ovf   (results.overflowed)
);

### bench/tb_decimal_text_to_fixed_point_unit.sv
`timescale 1ns / 1ps

module tb_decimal_text_to_fixed_point_unit;
  import dtfp_pkg::*;

  // block configuration as built, and the derived numeric limits
  localparam int VW      = VALUE_WIDTH_DEF;
  localparam int MAX_FD  = MAX_FRACTION_DIGITS_DEF;
  // registers a last-char request passes from the parser output to the result port
  localparam int LATENCY = MAX_FD + 1;
  localparam logic [63:0] HALF_SPAN = 64'd1 << (VW - 1);
  // minimum chars per random phase, eight phases in all
  localparam int PHASE_CHARS = 180;

  typedef struct packed {
    logic signed [VW-1:0] value;
    logic                 bad;
    logic                 ovf;
  } number_t;

  // one row of the directed table: a char request or a register write
  typedef struct {
    bit         is_cfg;
    logic [7:0] code;
    bit         last;
    bit         typed;
    number_t    want;
    logic [3:0] cfg;
  } step_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;

  dtfp_char_if                         chars_bus ();
  dtfp_result_if #(.VALUE_WIDTH(VW))   result_bus ();

  decimal_text_to_fixed_point_unit #(
    .VALUE_WIDTH        (VW),
    .MAX_FRACTION_DIGITS(MAX_FD)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .chars      (chars_bus),
    .results    (result_bus)
  );

  always #10 clk = ~clk;

  // numbers the parser still owes us, oldest first
  number_t awaited_numbers[$];
  step_t   steps[$];
  int      errors = 0;
  int      chars_sent = 0;
  int      send_idle_pct = 0;
  int      stall_pct = 0;

  // ---------------------------------------------------------------------
  // parser mirror: register copy and the per-number state
  // ---------------------------------------------------------------------
  logic [3:0]  fd_model;
  logic [63:0] acc_model;
  int          frac_taken;
  bit          dot_model, neg_model, first_model, err_model, ovf_model;

  function automatic void clear_number();
    acc_model   = '0;
    frac_taken  = 0;
    dot_model   = 1'b0;
    neg_model   = 1'b0;
    first_model = 1'b1;
    err_model   = 1'b0;
    ovf_model   = 1'b0;
  endfunction

  // negative numbers may reach one step further than positive ones
  function automatic logic [63:0] mag_ceiling();
    return neg_model ? HALF_SPAN : HALF_SPAN - 64'd1;
  endfunction

  // times ten plus digit, clamped at the ceiling
  function automatic void take_digit(input logic [63:0] d);
    logic [63:0] lim;
    lim = mag_ceiling();
    if (acc_model > (lim - d) / 10) begin
      acc_model = lim;
      ovf_model = 1'b1;
    end else begin
      acc_model = acc_model * 10 + d;
    end
  endfunction

  // folds one char into the mirror; returns 1 when a number completes
  function automatic bit parse_char(input logic [7:0] code, input bit last,
                                    output number_t res);
    int          kept;
    int          k;
    logic [63:0] mag;
    logic [63:0] lim;
    bit          was_first;
    // register values above the maximum act as the maximum
    kept = (fd_model > MAX_FD) ? MAX_FD : int'(fd_model);
    was_first = first_model;
    first_model = 1'b0;
    res = '0;
    if (code >= CHAR_ZERO && code <= CHAR_NINE) begin
      if (!dot_model) begin
        take_digit(code - CHAR_ZERO);
      end else if (frac_taken < kept) begin
        take_digit(code - CHAR_ZERO);
        frac_taken++;
      end
      // extra fraction digits simply fall away
    end else if (code == CHAR_DOT) begin
      if (dot_model) err_model = 1'b1;
      else dot_model = 1'b1;
    end else if ((code == CHAR_MINUS || code == CHAR_PLUS) && was_first) begin
      neg_model = (code == CHAR_MINUS);
    end else begin
      err_model = 1'b1;
    end
    if (!last) return 1'b0;
    // pad out the missing fraction digits, clamping on the way
    mag = acc_model;
    lim = mag_ceiling();
    for (k = frac_taken; k < kept; k++) begin
      if (mag > lim / 10) begin
        mag = lim;
        ovf_model = 1'b1;
      end else begin
        mag = mag * 10;
      end
    end
    mag = neg_model ? (64'd0 - mag) : mag;
    res.value = mag[VW-1:0];
    res.bad   = err_model;
    res.ovf   = ovf_model;
    clear_number();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // char side: one request per call, gaps drawn before each one
  // ---------------------------------------------------------------------
  task automatic send_char(input logic [7:0] code, input bit last, input bit typed,
                           input number_t typed_want);
    number_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      chars_bus.valid <= 1'b0;
      @(negedge clk);
    end
    chars_bus.valid     <= 1'b1;
    chars_bus.char_code <= code;
    chars_bus.last_char <= last;
    // ready is read before this edge's updates land
    do @(posedge clk); while (!chars_bus.ready);
    chars_sent++;
    if (parse_char(code, last, predicted))
      awaited_numbers.push_back(typed ? typed_want : predicted);
    @(negedge clk);
  endtask

  // hold off new requests until every owed number is back, then let the
  // scaling chain run dry
  task automatic wait_for_results();
    chars_bus.valid <= 1'b0;
    while (awaited_numbers.size() != 0) @(negedge clk);
    repeat (2 * LATENCY) @(negedge clk);
  endtask

  task automatic write_fraction_digits(input logic [3:0] v);
    wait_for_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    fd_model = v;
  endtask

  // ---------------------------------------------------------------------
  // directed table builders
  // ---------------------------------------------------------------------
  task automatic add_code(input logic [7:0] code, input bit last, input bit typed,
                          input number_t want);
    step_t s;
    s.is_cfg = 1'b0;
    s.code   = code;
    s.last   = last;
    s.typed  = typed;
    s.want   = want;
    s.cfg    = '0;
    steps.push_back(s);
  endtask

  // text as a run of requests; only the final char can carry the end mark, and only when ends is set
  task automatic add_chars(input string txt, input bit ends, input bit typed,
                           input logic signed [VW-1:0] v, input bit bad, input bit ovf);
    number_t want;
    want.value = v;
    want.bad   = bad;
    want.ovf   = ovf;
    foreach (txt[i])
      add_code(txt[i], ends && (i == txt.len() - 1), typed, want);
  endtask

  task automatic add_cfg(input logic [3:0] v);
    step_t s;
    s.is_cfg = 1'b1;
    s.code   = '0;
    s.last   = 1'b0;
    s.typed  = 1'b0;
    s.want   = '0;
    s.cfg    = v;
    steps.push_back(s);
  endtask

  // ---------------------------------------------------------------------
  // random numbers: mostly well-formed text, some limit strings, some noise
  // ---------------------------------------------------------------------
  task automatic send_random_number();
    logic [7:0] text[$];
    int         pick;
    int         n_int;
    int         n_frac;
    int         pos;
    bit         all_nines;
    string      lim_txt;
    logic [7:0] junk;
    pick = $urandom_range(99);
    if (pick < 8) begin
      // raw bytes, any code at all
      repeat ($urandom_range(6, 1)) text.push_back(8'($urandom_range(255)));
    end else if (pick < 14) begin
      // the signed limits as text, one either side
      case ($urandom_range(2))
        0: lim_txt = "140737488355327";
        1: lim_txt = "140737488355328";
        default: lim_txt = "140737488355329";
      endcase
      if ($urandom_range(1)) text.push_back(CHAR_MINUS);
      foreach (lim_txt[i]) text.push_back(lim_txt[i]);
    end else begin
      case ($urandom_range(2))
        1: text.push_back(CHAR_PLUS);
        2: text.push_back(CHAR_MINUS);
        default: ;
      endcase
      // now and then long enough to saturate
      n_int = ($urandom_range(9) == 0) ? $urandom_range(18) : $urandom_range(6);
      all_nines = ($urandom_range(4) == 0);
      repeat (n_int)
        text.push_back(all_nines ? CHAR_NINE : CHAR_ZERO + 8'($urandom_range(9)));
      if ($urandom_range(9) < 6) begin
        text.push_back(CHAR_DOT);
        n_frac = $urandom_range(12);
        repeat (n_frac)
          text.push_back(all_nines ? CHAR_NINE : CHAR_ZERO + 8'($urandom_range(9)));
      end
      if (text.size() == 0) text.push_back(CHAR_ZERO + 8'($urandom_range(9)));
      // occasional stray char: junk byte, extra dot or misplaced sign
      if ($urandom_range(9) == 0) begin
        case ($urandom_range(2))
          0: junk = 8'($urandom_range(255));
          1: junk = CHAR_DOT;
          default: junk = $urandom_range(1) ? CHAR_MINUS : CHAR_PLUS;
        endcase
        pos = $urandom_range(text.size());
        text.insert(pos, junk);
      end
    end
    foreach (text[i]) send_char(text[i], i == text.size() - 1, 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------
  // result side: random back-pressure, checks at the rising edge
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    result_bus.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    number_t want;
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (awaited_numbers.size() == 0) begin
        $error("result with no number pending: scaled_value %0d", result_bus.scaled_value);
        errors++;
      end else begin
        want = awaited_numbers.pop_front();
        if (result_bus.scaled_value !== want.value) begin
          $error("scaled_value: expected %0d, got %0d", want.value, result_bus.scaled_value);
          errors++;
        end
        if (result_bus.bad_character !== want.bad) begin
          $error("bad_character: expected %0b, got %0b", want.bad, result_bus.bad_character);
          errors++;
        end
        if (result_bus.overflowed !== want.ovf) begin
          $error("overflowed: expected %0b, got %0b", want.ovf, result_bus.overflowed);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------
  initial begin
    int cfg_plan[8];
    int phase;
    int start_count;
    rst                 = 1'b1;
    cfg_wr_en           = 1'b0;
    cfg_wr_data         = '0;
    chars_bus.valid     = 1'b0;
    chars_bus.char_code = '0;
    chars_bus.last_char = 1'b0;
    result_bus.ready    = 1'b1;
    fd_model            = FRACTION_DIGITS_RESET;
    clear_number();

    // directed part, register at its reset value of four digits
    add_chars("-1.5", 1, 1, -15000, 0, 0);
    // sign and dot with no digit after them is an empty number
    add_chars("+.", 1, 1, 0, 0, 0);
    // negative zero comes out as plain zero
    add_chars("-0", 1, 1, 0, 0, 0);
    // second dot and a sign past the first char are both flagged and skipped
    add_chars("3..-", 1, 1, 30000, 1, 0);
    // extreme codes, neither one a digit
    add_code(8'hFF, 0, 0, '0);
    add_code(8'h00, 1, 1, '{value: '0, bad: 1'b1, ovf: 1'b0});
    // register drops below the fraction digits already taken: no scaling
    add_chars("1.23", 0, 0, 0, 0, 0);
    add_cfg(4'd1);
    add_chars("4", 1, 0, 0, 0, 0);
    // register above the maximum acts as nine digits; clamps at the low limit
    add_cfg(4'd15);
    add_chars("-999999", 1, 1, {1'b1, {(VW-1){1'b0}}}, 0, 1);

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (steps[i]) begin
      if (steps[i].is_cfg)
        write_fraction_digits(steps[i].cfg);
      else
        send_char(steps[i].code, steps[i].last, steps[i].typed, steps[i].want);
    end

    // random part: register settings incl. both ends, under each idling mix
    cfg_plan = '{0, 9, 15, 4, 1, 6, 0, 0};
    cfg_plan[6] = $urandom_range(15);
    cfg_plan[7] = $urandom_range(15);
    for (phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 46; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 46; end
        default: begin send_idle_pct = 30; stall_pct = 30; end
      endcase
      write_fraction_digits(cfg_plan[phase]);
      start_count = chars_sent;
      while (chars_sent - start_count < PHASE_CHARS) begin
        send_random_number();
        // sometimes let the output side empty out completely
        if ($urandom_range(99) < 3) wait_for_results();
      end
    end

    wait_for_results();
    if (errors == 0 && awaited_numbers.size() == 0) begin
      $display("PASS decimal_text_to_fixed_point_unit");
    end else begin
      $display("FAIL decimal_text_to_fixed_point_unit");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #4_000_000;
    $display("FAIL decimal_text_to_fixed_point_unit");
    $finish;
  end

endmodule
